// ===== rtl/bsa_pkg.sv =====
// Shared types, operation codes and the first-zero encoder for the
// bitmap slot allocator. No dependencies.
package bsa_pkg;

    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int IDX_W  = 10;
    localparam int MODE_W = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [IDX_W-1:0]  t_index;

    localparam t_mode MODE_ALLOC     = 2'd0;
    localparam t_mode MODE_MARK_USED = 2'd1;
    localparam t_mode MODE_MARK_FREE = 2'd2;
    localparam t_mode MODE_QUERY     = 2'd3;

    // Position of the lowest clear bit; 0 when the word is all ones.
    function automatic logic [BIT_W-1:0] first_zero(input t_word w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: first-fit allocation over a
// two-level bitmap held in two instances of bsa_ram. Depends on bsa_pkg.
//
// Bitmap slot allocator. A request is taken at a clock edge where start is
// high and busy is low; every request gives exactly one result, shown on
// o_granted_index / o_flag for a single cycle with o_valid high, and the
// receiver must take it then (there is no back-pressure). Allocate passes
// through the states S_ASUM and S_AWORD, a mark through S_MARK and a query
// through S_QUERY; the result is registered as the last of them is left.
// Allocate on a full map and marks or queries beyond the slot count are
// answered straight from the idle state and change nothing. busy is low in
// the cycle that shows the result. Allocate and the marks each do a
// read-modify-write through the memories: allocate reads a summary word (one
// flag per full bitmap word), then the bitmap word it points at, then writes
// both back; a small register of per-summary-word full flags picks the
// summary word. After reset the memories are cleared with busy high.
// Slot 0 is never granted, and bits past SLOT_COUNT count as used.
module bitmap_slot_allocator import bsa_pkg::*; #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    input  t_mode  i_mode,
    input  t_index i_slot_index,
    output logic   busy,
    output logic   o_valid,
    output t_index o_granted_index,
    output logic   o_flag
);

    // Geometry: bitmap words, summary words, and their address widths.
    localparam int NW   = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int NS   = (NW + WORD_W - 1) / WORD_W;
    localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int SAW  = (NS > 1) ? $clog2(NS) : 1;
    localparam int WDW  = SAW + BIT_W;
    localparam int XW   = WDW + BIT_W;
    localparam int DREM = SLOT_COUNT % WORD_W;
    localparam int SREM = NW % WORD_W;

    // Bits past the end of the last word read as used / full.
    localparam t_word DPAD = (DREM == 0) ? '0 : ~t_word'((64'd1 << DREM) - 64'd1);
    localparam t_word SPAD = (SREM == 0) ? '0 : ~t_word'((64'd1 << SREM) - 64'd1);
    localparam logic [WDW-1:0] LAST_W = WDW'(NW - 1);
    localparam logic [SAW-1:0] LAST_S = SAW'(NS - 1);
    localparam logic [WAW-1:0] LAST_C = WAW'(NW - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_ASUM  = 3'd2;
    localparam logic [2:0] S_AWORD = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_QUERY = 3'd5;

    logic [2:0]     r_state, n_state;
    logic [WAW-1:0] r_clr_cnt, n_clr_cnt;
    logic [NS-1:0]  r_top, n_top;
    logic [WDW-1:0] r_word, n_word;
    logic [BIT_W-1:0] r_bit, n_bit;
    t_word          r_sum, n_sum;
    logic           r_set, n_set;
    logic           r_valid, n_valid;
    t_index         r_granted, n_granted;
    logic           r_flag, n_flag;

    // Memory ports.
    logic           data_we, sum_we;
    logic [WAW-1:0] data_waddr, data_raddr;
    logic [SAW-1:0] sum_waddr, sum_raddr;
    t_word          data_wdata, data_rdata, sum_wdata, sum_rdata;

    // Datapath.
    logic [XW-1:0]    idx_ext;
    logic             in_range;
    logic [SAW-1:0]   top_free;
    logic             top_full;
    logic [SAW-1:0]   cur_sa;
    logic [BIT_W-1:0] cur_sbit;
    t_word            sum_raw, sum_eff, data_eff, new_data, new_sum;
    logic [BIT_W-1:0] sum_fz, data_fz;
    logic             new_full, sum_full_new;

    function automatic t_word data_pad(input logic [WDW-1:0] w);
        t_word p;
        p = (w == LAST_W) ? DPAD : '0;
        if (w == '0) begin
            p[0] = 1'b1;    // slot 0 is never handed out
        end
        return p;
    endfunction

    function automatic t_word sum_pad(input logic [SAW-1:0] s);
        return (s == LAST_S) ? SPAD : '0;
    endfunction

    bsa_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    bsa_ram #(.WIDTH(WORD_W), .DEPTH(NS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // Lowest summary word that still has a free bitmap word.
    always_comb begin
        top_free = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_top[i]) begin
                top_free = SAW'(i);
            end
        end
    end

    assign top_full = &r_top;
    assign idx_ext  = XW'(i_slot_index);
    assign in_range = ({1'b0, idx_ext} < (XW + 1)'(SLOT_COUNT));
    assign cur_sa   = r_word[WDW-1:BIT_W];
    assign cur_sbit = r_word[BIT_W-1:0];

    // Summary word: registered copy on the allocate write-back, fresh read otherwise.
    assign sum_raw  = (r_state == S_AWORD) ? r_sum : sum_rdata;
    assign sum_eff  = sum_rdata | sum_pad(cur_sa);
    assign sum_fz   = first_zero(sum_eff);
    assign data_eff = data_rdata | data_pad(r_word);
    assign data_fz  = first_zero(data_eff);

    always_comb begin
        if (r_state == S_AWORD) begin
            new_data = data_rdata | (t_word'(1) << data_fz);
        end else if (r_set) begin
            new_data = data_rdata | (t_word'(1) << r_bit);
        end else begin
            new_data = data_rdata & ~(t_word'(1) << r_bit);
        end
        new_full     = &(new_data | data_pad(r_word));
        new_sum      = (sum_raw & ~(t_word'(1) << cur_sbit))
                     | (t_word'(new_full) << cur_sbit);
        sum_full_new = &(new_sum | sum_pad(cur_sa));
    end

    // Memory addressing and write-back.
    always_comb begin
        data_raddr = (r_state == S_ASUM) ? WAW'({cur_sa, sum_fz}) : WAW'(idx_ext[XW-1:BIT_W]);
        sum_raddr  = (i_mode == MODE_ALLOC) ? top_free : idx_ext[XW-1:2*BIT_W];
        if (r_state == S_CLEAR) begin
            data_we    = 1'b1;
            data_waddr = r_clr_cnt;
            data_wdata = (r_clr_cnt == '0) ? t_word'(1) : '0;
            sum_we     = ({1'b0, r_clr_cnt} < (WAW + 1)'(NS));
            sum_waddr  = SAW'(r_clr_cnt);
            sum_wdata  = '0;
        end else begin
            data_we    = (r_state == S_AWORD) || (r_state == S_MARK);
            data_waddr = WAW'(r_word);
            data_wdata = new_data;
            sum_we     = data_we;
            sum_waddr  = cur_sa;
            sum_wdata  = new_sum;
        end
    end

    // Request sequencing.
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_top     = r_top;
        n_word    = r_word;
        n_bit     = r_bit;
        n_sum     = r_sum;
        n_set     = r_set;
        n_valid   = 1'b0;
        n_granted = r_granted;
        n_flag    = r_flag;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_word = idx_ext[XW-1:BIT_W];
                    n_bit  = idx_ext[BIT_W-1:0];
                    n_set  = (i_mode == MODE_MARK_USED);
                    unique case (i_mode)
                        MODE_ALLOC: begin
                            if (top_full) begin
                                // Full map: answer at once, change nothing.
                                n_valid   = 1'b1;
                                n_granted = '0;
                                n_flag    = 1'b0;
                            end else begin
                                n_word  = {top_free, {BIT_W{1'b0}}};
                                n_state = S_ASUM;
                            end
                        end
                        MODE_MARK_USED, MODE_MARK_FREE: begin
                            if (in_range) begin
                                n_state = S_MARK;
                            end else begin
                                n_valid   = 1'b1;
                                n_granted = '0;
                                n_flag    = 1'b1;
                            end
                        end
                        default: begin
                            if (in_range) begin
                                n_state = S_QUERY;
                            end else begin
                                n_valid   = 1'b1;
                                n_granted = '0;
                                n_flag    = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_C) begin
                    n_state = S_IDLE;
                end
            end
            S_ASUM: begin
                // Pick the bitmap word and hold the summary word for write-back.
                n_word  = {cur_sa, sum_fz};
                n_sum   = sum_rdata;
                n_state = S_AWORD;
            end
            S_AWORD: begin
                n_top[cur_sa] = sum_full_new;
                n_valid   = 1'b1;
                n_granted = IDX_W'({r_word, data_fz});
                n_flag    = 1'b1;
                n_state   = S_IDLE;
            end
            S_MARK: begin
                n_top[cur_sa] = sum_full_new;
                n_valid   = 1'b1;
                n_granted = '0;
                n_flag    = 1'b1;
                n_state   = S_IDLE;
            end
            S_QUERY: begin
                n_valid   = 1'b1;
                n_granted = '0;
                n_flag    = ~data_rdata[r_bit];
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_top     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_top     <= n_top;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_bit     <= n_bit;
        r_sum     <= n_sum;
        r_set     <= n_set;
        r_granted <= n_granted;
        r_flag    <= n_flag;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_granted_index = r_granted;
    assign o_flag          = r_flag;

`ifndef SYNTH
    // A summary word picked by the top flags must have a free bitmap word.
    a_sum_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASUM) |-> !(&sum_eff))
        else $error("summary word chosen for allocate is full");

    // The bitmap word picked through the summary must have a free slot.
    a_word_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWORD) |-> !(&data_eff))
        else $error("bitmap word chosen for allocate is full");

    // Allocate on a full map answers next cycle with no grant.
    a_full_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_ALLOC) && top_full)
        |=> (o_valid && !o_flag && (o_granted_index == '0)))
        else $error("allocate on full map answered wrongly");

    // No result leaves the block while the bitmap is being cleared.
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("result during clearing pass");
`endif

endmodule

// ===== rtl/bsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
